### hw/rtl/dqs_pkg.sv
package dqs_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_FIND       = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // per-cell load selects, at most one high in a cycle, and an in-use flag
   typedef struct packed {
      logic take_left;
      logic take_right;
      logic take_value;
      logic in_use;
   } cell_ctrl_type;

endpackage

### hw/rtl/dqs_cell.sv
module dqs_cell
   import dqs_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [WORD_W-1:0]   left_data,
   input  logic [WORD_W-1:0]   right_data,
   input  logic [WORD_W-1:0]   value,
   output logic [WORD_W-1:0]   data,
   output logic                hit
);

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      priority if (ctrl.take_left) begin
         data_in = left_data;
      end else if (ctrl.take_right) begin
         data_in = right_data;
      end else if (ctrl.take_value) begin
         data_in = value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign hit  = ctrl.in_use && (data_ff == value);

endmodule

### hw/rtl/deque_with_value_search_unit.sv
// Bounded double-ended queue of signed 32-bit words with a find by value.
// Requests arrive on the req_ stream: req_tuser carries the opcode (push front,
// push back, pop front, pop back, find), req_tdata the word to push or to look
// for. Every request gives exactly one word on the rsp_ stream with a status,
// the popped word, the 1-based match position from the front, a found flag and
// the entry count after the request.
// Storage is a row of DEPTH shifting cells with the front in cell 0; pushes and
// pops at the front shift the whole row by one cell, and find compares every
// cell against the value at once and takes the lowest hit.
// Each request completes with its response in the output register on the cycle
// after acceptance, and one request per cycle is taken as long as the output
// is drained. The row shift and the parallel compare with its priority pick
// are combinational, ahead of the output register.
// While a response waits with rsp_tready low, req_tready drops and the queue
// holds still. Reset empties the queue (count to zero) and clears the output
// valid; cell contents are not cleared and are never read before written.
// A push to a full queue or a pop from an empty one is refused with a status
// code and leaves the contents unchanged.
module deque_with_value_search_unit
   import dqs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] popped_value, [36:32] match_position,
                                    // [37] match_found, [42:38] entry_count, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   logic                count_full;
   logic                count_empty;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          status_ff;
   logic [WORD_W-1:0]   popped_ff;
   logic [CNT_W-1:0]    pos_ff;
   logic                found_ff;

   logic                accept;
   op_type              op;
   status_type          status_next;
   logic                do_push_front;
   logic                do_push_back;
   logic                do_pop_front;
   logic                do_pop_back;
   logic                do_find;
   logic [WORD_W-1:0]   value;
   logic [WORD_W-1:0]   back_word;
   logic [WORD_W-1:0]   popped_next;
   logic [CNT_W-1:0]    hit_pos;
   logic                hit_any;

   logic [WORD_W-1:0]   cell_data [DEPTH];
   logic [DEPTH-1:0]    cell_hit;
   cell_ctrl_type       cell_ctrl [DEPTH];

   assign accept      = req_tvalid && req_tready;
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign op          = op_type'(req_tuser);
   assign value       = req_tdata;
   assign count_full  = (count_ff == CNT_W'(DEPTH));
   assign count_empty = (count_ff == '0);

   always_comb begin
      status_next   = ST_OK;
      do_push_front = 1'b0;
      do_push_back  = 1'b0;
      do_pop_front  = 1'b0;
      do_pop_back   = 1'b0;
      do_find       = 1'b0;
      unique case (op)
         OP_PUSH_FRONT: begin
            if (count_full) status_next = ST_FULL;
            else do_push_front = accept;
         end
         OP_PUSH_BACK: begin
            if (count_full) status_next = ST_FULL;
            else do_push_back = accept;
         end
         OP_POP_FRONT: begin
            if (count_empty) status_next = ST_EMPTY;
            else do_pop_front = accept;
         end
         OP_POP_BACK: begin
            if (count_empty) status_next = ST_EMPTY;
            else do_pop_back = accept;
         end
         OP_FIND: begin
            do_find = 1'b1;
         end
         default: begin
            status_next = ST_OK;
         end
      endcase
   end

   // row of cells, front at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_data;
      logic [WORD_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = value;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      assign cell_ctrl[i].take_left  = do_push_front;
      assign cell_ctrl[i].take_right = do_pop_front;
      assign cell_ctrl[i].take_value = do_push_back && (count_ff == CNT_W'(i));
      assign cell_ctrl[i].in_use     = (count_ff > CNT_W'(i));

      dqs_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .left_data  (left_data),
         .right_data (right_data),
         .value      (value),
         .data       (cell_data[i]),
         .hit        (cell_hit[i])
      );
   end

   // word at the back, and lowest hit for find
   always_comb begin
      back_word = '0;
      hit_pos   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (count_ff == CNT_W'(i + 1)) begin
            back_word = back_word | cell_data[i];
         end
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (cell_hit[i]) begin
            hit_pos = CNT_W'(i + 1);
         end
      end
   end

   assign hit_any = |cell_hit;

   always_comb begin
      popped_next = '0;
      if (do_pop_front) popped_next = cell_data[0];
      else if (do_pop_back) popped_next = back_word;
   end

   always_comb begin
      count_in = count_ff;
      if (do_push_front || do_push_back) count_in = count_ff + CNT_W'(1);
      else if (do_pop_front || do_pop_back) count_in = count_ff - CNT_W'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_next;
         popped_ff <= popped_next;
         pos_ff    <= (do_find && hit_any) ? hit_pos : '0;
         found_ff  <= do_find && hit_any;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {5'b0, count_ff, found_ff, pos_ff, popped_ff};

endmodule

### verif/deque_with_value_search_unit_tb.sv
module deque_with_value_search_unit_tb;
   import dqs_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      status_type  status;
      logic [31:0] popped;
      logic [4:0]  pos;
      logic        found;
      logic [4:0]  count;
   } dq_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   // words held by the shadow deque, front at index 0
   logic [31:0]  shadow_words[$];
   dq_reply_type pending_replies[$];

   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned fail_count = 0;

   deque_with_value_search_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic dq_reply_type deque_apply(logic [2:0] op, logic [31:0] value);
      dq_reply_type r;
      int           i;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (shadow_words.size() >= DEPTH)
               r.status = ST_FULL;
            else if (op == OP_PUSH_FRONT)
               shadow_words.push_front(value);
            else
               shadow_words.push_back(value);
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (shadow_words.size() == 0)
               r.status = ST_EMPTY;
            else if (op == OP_POP_FRONT)
               r.popped = shadow_words.pop_front();
            else
               r.popped = shadow_words.pop_back();
         end
         OP_FIND: begin
            // first hit from the front wins
            for (i = 0; i < shadow_words.size() && !r.found; i++) begin
               if (shadow_words[i] == value) begin
                  r.pos = 5'(i + 1);
                  r.found = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.count = 5'(shadow_words.size());
      return r;
   endfunction

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_reply();
      dq_reply_type want;
      if (pending_replies.size() == 0) begin
         $error("response word with no request pending");
         fail_count++;
      end else begin
         want = pending_replies.pop_front();
         compare_field("status", 32'(want.status), 32'(rsp_tuser));
         compare_field("popped_value", want.popped, rsp_tdata[31:0]);
         compare_field("match_position", 32'(want.pos), 32'(rsp_tdata[36:32]));
         compare_field("match_found", 32'(want.found), 32'(rsp_tdata[37]));
         compare_field("entry_count", 32'(want.count), 32'(rsp_tdata[42:38]));
         compare_field("tdata padding", 32'd0, 32'(rsp_tdata[47:43]));
      end
   endtask

   // outputs are sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            check_reply();
         if (req_tvalid && req_tready)
            pending_replies.push_back(deque_apply(req_tuser, req_tdata));
      end
   end

   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL deque_with_value_search_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(logic [2:0] op, logic [31:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= value;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
   endtask

   // small pool so pushes repeat and finds hit
   function automatic logic [31:0] pick_value();
      case ($urandom_range(11))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         5: return 32'h5555_5555;
         6: return 32'haaaa_aaaa;
         7: return 32'h0000_00ff;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed_cases();
      send_word(OP_POP_FRONT, 32'h1234_5678);
      send_word(OP_POP_BACK, 32'h0);
      send_word(OP_FIND, 32'h0);
      send_word(3'd5, 32'hffff_ffff);
      send_word(3'd6, 32'h0);
      // push back onto empty, then pop back of the only entry
      send_word(OP_PUSH_BACK, 32'h7fff_ffff);
      send_word(OP_POP_BACK, 32'h0);
      send_word(OP_PUSH_BACK, 32'h8000_0000);
      send_word(OP_PUSH_FRONT, 32'hffff_ffff);
      send_word(OP_PUSH_FRONT, 32'h0000_0000);
      send_word(OP_PUSH_BACK, 32'h7fff_ffff);
      send_word(OP_FIND, 32'h7fff_ffff);
      send_word(OP_FIND, 32'h0000_0000);
      send_word(OP_FIND, 32'h8000_0000);
      send_word(OP_FIND, 32'h0001_2345);
      send_word(OP_PUSH_BACK, 32'hffff_ffff);
      send_word(OP_FIND, 32'hffff_ffff);
      send_word(3'd7, 32'h8000_0000);
      send_word(OP_POP_FRONT, 32'hffff_ffff);
      send_word(OP_POP_BACK, 32'h0);
      send_word(OP_POP_BACK, 32'h0);
      send_word(OP_POP_FRONT, 32'h0);
      send_word(OP_POP_FRONT, 32'h0);
      send_word(OP_POP_FRONT, 32'h0);
      wait_drained();
   endtask

   task automatic test_full_queue();
      logic [31:0] fill_words[DEPTH];
      int          k;
      for (k = 0; k < DEPTH; k++) begin
         fill_words[k] = $urandom();
         send_word(OP_PUSH_BACK, fill_words[k]);
      end
      send_word(OP_PUSH_BACK, $urandom());
      send_word(OP_PUSH_FRONT, $urandom());
      send_word(OP_FIND, fill_words[DEPTH-1]);
      send_word(OP_FIND, fill_words[0]);
      send_word(3'd5, $urandom());
      for (k = 0; k < DEPTH; k++)
         send_word((k % 2 == 0) ? OP_POP_FRONT : OP_POP_BACK, $urandom());
      send_word(OP_POP_BACK, $urandom());
      for (k = 0; k < DEPTH; k++)
         send_word(OP_PUSH_FRONT, $urandom());
      send_word(OP_PUSH_FRONT, $urandom());
      for (k = 0; k < DEPTH; k++)
         send_word(OP_POP_BACK, $urandom());
      wait_drained();
   endtask

   task automatic test_random_traffic(int unsigned n_items);
      int unsigned push_pct;
      int unsigned pick;
      int unsigned k;
      logic [2:0]  op;
      push_pct = 50;
      for (k = 0; k < n_items; k++) begin
         // swing the fill level so both full and empty come up often
         if (k % 40 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 15;
               1: push_pct = 50;
               default: push_pct = 85;
            endcase
         end
         pick = $urandom_range(99);
         if (pick < 3)
            op = 3'($urandom_range(7, 5));
         else if (pick < 25)
            op = OP_FIND;
         else if ($urandom_range(99) < push_pct)
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else
            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
         send_word(op, pick_value());
      end
      wait_drained();
   endtask

   task automatic test_output_stall();
      int k;
      req_idle_pct = 0;
      rsp_hold_left <= 60;
      for (k = 0; k < 30; k++)
         send_word(($urandom_range(2) == 0) ? OP_FIND : OP_PUSH_BACK, pick_value());
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 35;
      rsp_idle_pct = 72;
      test_directed_cases();
      test_full_queue();
      test_random_traffic(500);

      req_idle_pct = 72;
      rsp_idle_pct = 35;
      test_random_traffic(500);

      rsp_idle_pct = 0;
      test_output_stall();

      req_idle_pct = 0;
      test_random_traffic(600);

      repeat (5) @(posedge clock);
      if (pending_replies.size() != 0) begin
         $error("%0d responses never arrived", pending_replies.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("PASS deque_with_value_search_unit");
      else
         $display("FAIL deque_with_value_search_unit");
      $finish;
   end

endmodule

### deque_with_value_search_unit.f
hw/rtl/dqs_pkg.sv
hw/rtl/dqs_cell.sv
hw/rtl/deque_with_value_search_unit.sv
verif/deque_with_value_search_unit_tb.sv
